>>> src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Operation codes, status codes, default depth and the controller command
// bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int DATA_W        = 32;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_REAR   = 3'd3;
  localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
  localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic load;     // capture the incoming request
    logic exec;     // perform the captured operation
    logic respond;  // present the result for one cycle
  } cdq_cmd_t;

endpackage

>>> src/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue in a ring of DEPTH slots
// After the edge that accepts start the controller is in execute, then in
// respond, where the result strobe is high and the result is taken.
// Each request passes capture, execute with the one slot access, and respond;
// a new one is accepted only back in idle, and busy is high in execute and respond.
// Reset (rst_n low, synchronous) empties the deque; slot contents stay unset.
// The receiver cannot stall: each result is marked on out_valid for one cycle.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic [1:0]               out_status,
  output logic                     out_now_empty,
  output logic                     out_now_full
);

  // The controller sequences each request; the datapath holds the slots and
  // the front and rear pointers. One slot always stays free, so the ring holds
  // at most DEPTH-1 values, and full is detected when the rear pointer's
  // successor meets the front pointer.
  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Rejected pushes and pops report full or empty status and leave the
  // pointers untouched; the flags always reflect the state after the request.
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .res_data   (out_data),
    .res_status (out_status),
    .res_empty  (out_now_empty),
    .res_full   (out_now_full)
  );

  // The respond phase lasts exactly one cycle per request.
  assign out_valid = cmd.respond;

endmodule

>>> src/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: request sequencer
// Walks each request through capture, execute and respond.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output cdq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.respond = (state_r == S_RESP);

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted request did not enter execute");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.respond)
    else $error("execute was not followed by a response");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.respond}))
    else $error("more than one command active");

endmodule

>>> src/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: slot memory, ring pointers and result registers
// Executes one captured operation when commanded.
// ----------------------------------------------------------------------------
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_cmd_t                 cmd,
  input  logic [2:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] res_data,
  output logic [1:0]               res_status,
  output logic                     res_empty,
  output logic                     res_full
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [2:0]        kind_r;
  logic [DATA_W-1:0] value_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [AW-1:0]     rear_r, rear_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_hit_r;

  logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic          empty, full;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  assign front_inc = (front_r == LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LAST : front_r - 1'b1;
  assign rear_inc  = (rear_r == LAST) ? '0 : rear_r + 1'b1;
  assign rear_dec  = (rear_r == '0) ? LAST : rear_r - 1'b1;
  assign empty     = (front_r == rear_r);
  assign full      = (rear_inc == front_r);

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    status_nxt = STAT_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = front_r;
    rd_addr    = rear_r;
    unique case (kind_r)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = front_r;
          front_nxt = front_dec;
        end
      end
      KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = rear_inc;
          rear_nxt = rear_inc;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = front_inc;
          front_nxt = front_inc;
        end
      end
      KIND_POP_REAR: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = rear_r;
          rear_nxt = rear_dec;
        end
      end
      KIND_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_inc;
        end
      end
      KIND_PEEK_REAR: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rear_r;
        end
      end
      default: begin
        // Unknown operations leave everything alone and report ok.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r  <= status_nxt;
      rd_data_r <= mem[rd_addr];
      if (wr_en) begin
        mem[wr_addr] <= value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      rd_hit_r <= 1'b0;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      rd_hit_r <= rd_en;
    end
  end

  assign res_data   = rd_hit_r ? signed'(rd_data_r) : '0;
  assign res_status = status_r;
  assign res_empty  = empty;
  assign res_full   = full;

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST)
    else $error("front pointer left the ring");

  a_rear_range: assert property (@(posedge clk) disable iff (!rst_n)
    rear_r <= LAST)
    else $error("rear pointer left the ring");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt != STAT_OK) |=> ($stable(front_r) && $stable(rear_r)))
    else $error("rejected operation moved a pointer");

endmodule
